>>> src/i2c_ras_pkg.sv
// Shared types and constants for the I2C register access sequencer.
`default_nettype none
package i2c_ras_pkg;

	// Bus engine command codes
	typedef enum logic [2:0] {
		CMD_NONE   = 3'd0,
		CMD_START  = 3'd1,
		CMD_RSTART = 3'd2,
		CMD_STOP   = 3'd3,
		CMD_SEND   = 3'd4,
		CMD_RECV   = 3'd5,
		CMD_ACK    = 3'd6,
		CMD_NAK    = 3'd7
	} cmd_t;

	// Request operation codes
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_LOAD  = 2'd1,
		OP_READ  = 2'd2,
		OP_WRITE = 2'd3
	} op_t;

	// Register indexes on the configuration port (paddr[2])
	localparam logic REG_RX_TIMEOUT = 1'b0;
	localparam logic REG_STARTUP    = 1'b1;

	localparam int unsigned DEF_BUFFER_DEPTH = 16;
	localparam logic [7:0]  RX_TIMEOUT_RST   = 8'd25;
	localparam logic [15:0] STARTUP_RST      = 16'd1000;

	// Read/write bit appended to the address byte
	localparam logic [7:0]  ADDR_RD_BIT      = 8'h01;

endpackage : i2c_ras_pkg
`default_nettype wire

>>> src/i2c_register_access_sequencer_unit.sv
// Top level of the I2C register access sequencer: request register, step logic, result register.
`default_nettype none
// Each request is one step of the transaction sequencer. Requests are taken one per clock
// while out_stall does not hold the result register: a request is captured in an input
// register, then the step logic runs on it against the sequencer state and writes the result
// register. Throughput is otherwise set by the single-step state update. After reset the
// sequencer counts startup_ticks requests, then emits a stop and goes idle. Read requests are
// served before write requests; a header NAK on a read retries it after a stop, a NAK on a
// write abandons it. The transmit buffer has no reset; entries must be loaded before use.
module i2c_register_access_sequencer_unit
	import i2c_ras_pkg::*;
#(
	parameter int unsigned BUFFER_DEPTH = DEF_BUFFER_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  operation,
	input  wire logic [6:0]  slave_address,
	input  wire logic [7:0]  register_address,
	input  wire logic [7:0]  byte_count,
	input  wire logic [3:0]  tx_index,
	input  wire logic [7:0]  tx_data,
	input  wire logic        engine_busy,
	input  wire logic        slave_nak,
	input  wire logic        rx_full,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        stop_seen,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       command,
	output logic [7:0]       command_byte,
	output logic             rx_valid,
	output logic [3:0]       rx_index,
	output logic [7:0]       rx_data,
	output logic             busy_res,
	output logic             comm_error,
	output logic             read_pending,
	output logic             write_pending,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int unsigned IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int unsigned POS_W = $clog2(BUFFER_DEPTH + 1);
	localparam logic [POS_W-1:0] POS_DEPTH = POS_W'(BUFFER_DEPTH);
	localparam logic [8:0] IDX_LIMIT = 9'(BUFFER_DEPTH);

	typedef enum logic [4:0] {
		S_INIT, S_WAIT, S_IDLE,
		S_R_WAITBUS, S_R_ADDRW, S_R_ADDRW_CHK, S_R_REG_CHK, S_R_ADDRR, S_R_ADDRR_CHK,
		S_R_RECV, S_R_POLL, S_R_END,
		S_W_START, S_W_ADDR, S_W_ADDR_CHK, S_W_REG, S_W_REG_CHK, S_W_DATA, S_W_DATA_CHK,
		S_W_END
	} state_t;

	// configuration registers
	logic [7:0]  rx_timeout_q;
	logic [15:0] startup_ticks_q;

	// input register
	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [6:0]  saddr_s1;
	logic [7:0]  raddr_s1;
	logic [7:0]  count_s1;
	logic [3:0]  tx_idx_s1;
	logic [7:0]  tx_data_s1;
	logic        ebusy_s1;
	logic        nak_s1;
	logic        rfull_s1;
	logic [7:0]  rbyte_s1;
	logic        stopped_s1;

	// sequencer state
	state_t           state_q;
	logic [15:0]      startup_cnt_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0]       bytes_left_q;
	logic [7:0]       timeout_cnt_q;
	logic [6:0]       tgt_addr_q;
	logic [7:0]       tgt_reg_q;
	logic             busy_q, err_q, rd_q, wr_q;
	logic [7:0]       tx_buf_q [BUFFER_DEPTH];

	// result register
	logic        valid_s2;
	cmd_t        cmd_s2;
	logic [7:0]  cbyte_s2;
	logic        rxv_s2;
	logic [3:0]  rxi_s2;
	logic [7:0]  rxd_s2;
	logic        busy_s2, err_s2, rd_s2, wr_s2;

	logic advance;
	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;

	// configuration writes and reads
	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_timeout_q    <= RX_TIMEOUT_RST;
			startup_ticks_q <= STARTUP_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_RX_TIMEOUT) rx_timeout_q <= pwdata[7:0];
			else startup_ticks_q <= pwdata[15:0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_STARTUP) prdata = {16'd0, startup_ticks_q};
		else prdata = {24'd0, rx_timeout_q};
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1      <= operation;
			saddr_s1   <= slave_address;
			raddr_s1   <= register_address;
			count_s1   <= byte_count;
			tx_idx_s1  <= tx_index;
			tx_data_s1 <= tx_data;
			ebusy_s1   <= engine_busy;
			nak_s1     <= slave_nak;
			rfull_s1   <= rx_full;
			rbyte_s1   <= rx_byte;
			stopped_s1 <= stop_seen;
		end
	end

	// transmit buffer load, with bypass for the same request
	logic             load_en;
	logic [IDX_W-1:0] load_addr;
	logic [IDX_W-1:0] rd_addr;
	logic [7:0]       buf_rd;
	assign load_en   = valid_s1 && advance && (op_s1 == OP_LOAD)
		&& (9'(tx_idx_s1) < IDX_LIMIT);
	assign load_addr = IDX_W'(tx_idx_s1);
	assign rd_addr   = pos_q[IDX_W-1:0];

	always_comb begin
		if (pos_q >= POS_DEPTH) buf_rd = 8'd0;
		else if (load_en && (load_addr == rd_addr)) buf_rd = tx_data_s1;
		else buf_rd = tx_buf_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (load_en) tx_buf_q[load_addr] <= tx_data_s1;
	end

	// one sequencer step
	state_t           st_n;
	logic [15:0]      startup_n;
	logic [POS_W-1:0] pos_n;
	logic [POS_W-1:0] pos_inc;
	logic [7:0]       left_n;
	logic [7:0]       left_dec;
	logic [7:0]       tmo_n;
	logic [6:0]       addr_n;
	logic [7:0]       reg_n;
	logic             busy_n, err_n, rd_n, wr_n;
	cmd_t             cmd_n;
	logic [7:0]       cbyte_n;
	logic             rxv_n;
	logic [3:0]       rxi_n;
	logic [7:0]       rxd_n;
	logic             last_byte;

	// bytes are only counted while busy, so no request can replace the count that step
	assign pos_inc   = pos_q + POS_W'(1);
	assign left_dec  = bytes_left_q - 8'd1;

	always_comb begin
		st_n      = state_q;
		startup_n = startup_cnt_q;
		pos_n     = pos_q;
		left_n    = bytes_left_q;
		tmo_n     = timeout_cnt_q;
		addr_n    = tgt_addr_q;
		reg_n     = tgt_reg_q;
		busy_n    = busy_q;
		err_n     = err_q;
		rd_n      = rd_q;
		wr_n      = wr_q;
		cmd_n     = CMD_NONE;
		cbyte_n   = 8'd0;
		rxv_n     = 1'b0;
		rxi_n     = 4'd0;
		rxd_n     = 8'd0;
		last_byte = 1'b0;

		// request taken only while not busy
		if ((op_s1 == OP_READ || op_s1 == OP_WRITE) && !busy_q) begin
			addr_n = saddr_s1;
			reg_n  = raddr_s1;
			left_n = count_s1;
			if (op_s1 == OP_READ) rd_n = 1'b1;
			else wr_n = 1'b1;
		end

		case (state_q)
			S_INIT: begin
				busy_n    = 1'b1;
				err_n     = 1'b0;
				rd_n      = 1'b0;
				wr_n      = 1'b0;
				reg_n     = 8'd0;
				pos_n     = '0;
				startup_n = startup_ticks_q;
				st_n      = S_WAIT;
			end
			S_WAIT: begin
				if (startup_cnt_q > 16'd1) begin
					startup_n = startup_cnt_q - 16'd1;
				end else begin
					cmd_n  = CMD_STOP;
					busy_n = 1'b0;
					wr_n   = 1'b0;
					st_n   = S_IDLE;
				end
			end
			S_IDLE: begin
				if (rd_n || wr_n) begin
					cmd_n  = CMD_START;
					pos_n  = '0;
					busy_n = 1'b1;
					st_n   = rd_n ? S_R_ADDRW : S_W_ADDR;
				end
			end
			S_R_WAITBUS: begin
				if (stopped_s1) begin
					cmd_n = CMD_START;
					pos_n = '0;
					st_n  = S_R_ADDRW;
				end
			end
			S_R_ADDRW: begin
				cmd_n   = CMD_SEND;
				cbyte_n = {addr_n, 1'b0};
				st_n    = S_R_ADDRW_CHK;
			end
			S_R_ADDRW_CHK: begin
				if (!ebusy_s1) begin
					err_n = nak_s1;
					if (nak_s1) begin
						st_n = S_R_END;
					end else begin
						cmd_n   = CMD_SEND;
						cbyte_n = reg_n;
						st_n    = S_R_REG_CHK;
					end
				end
			end
			S_R_REG_CHK: begin
				if (!ebusy_s1) begin
					err_n = nak_s1;
					if (nak_s1) begin
						st_n = S_R_END;
					end else begin
						cmd_n = CMD_RSTART;
						st_n  = S_R_ADDRR;
					end
				end
			end
			S_R_ADDRR: begin
				cmd_n   = CMD_SEND;
				cbyte_n = {addr_n, 1'b0} | ADDR_RD_BIT;
				st_n    = S_R_ADDRR_CHK;
			end
			S_R_ADDRR_CHK: begin
				if (!ebusy_s1) begin
					err_n = nak_s1;
					if (nak_s1) begin
						st_n = S_R_END;
					end else begin
						cmd_n = CMD_RECV;
						tmo_n = 8'd0;
						st_n  = S_R_POLL;
					end
				end
			end
			S_R_RECV: begin
				cmd_n = CMD_RECV;
				tmo_n = 8'd0;
				st_n  = S_R_POLL;
			end
			S_R_POLL: begin
				if (!rfull_s1 && (timeout_cnt_q < rx_timeout_q)) begin
					tmo_n = timeout_cnt_q + 8'd1;
				end else begin
					if (rfull_s1) begin
						rxv_n = 1'b1;
						rxi_n = 4'(pos_q);
						rxd_n = rbyte_s1;
					end else begin
						err_n = 1'b1;
					end
					// a timed-out byte still counts toward the length
					left_n    = left_dec;
					pos_n     = pos_inc;
					last_byte = (left_dec == 8'd0) || (pos_inc >= POS_DEPTH);
					if (last_byte) begin
						cmd_n  = CMD_NAK;
						busy_n = 1'b0;
						rd_n   = 1'b0;
						st_n   = S_R_END;
					end else begin
						cmd_n = CMD_ACK;
						st_n  = S_R_RECV;
					end
				end
			end
			S_R_END: begin
				cmd_n = CMD_STOP;
				if (rd_n) begin
					busy_n = 1'b1;
					st_n   = S_R_WAITBUS;
				end else if (wr_n) begin
					busy_n = 1'b1;
					st_n   = S_W_START;
				end else begin
					st_n = S_IDLE;
				end
			end
			S_W_START: begin
				pos_n = '0;
				cmd_n = CMD_START;
				st_n  = S_W_ADDR;
			end
			S_W_ADDR: begin
				cmd_n   = CMD_SEND;
				cbyte_n = {addr_n, 1'b0};
				st_n    = S_W_ADDR_CHK;
			end
			S_W_ADDR_CHK: begin
				if (!ebusy_s1) begin
					err_n = nak_s1;
					st_n  = nak_s1 ? S_W_END : S_W_REG;
				end
			end
			S_W_REG: begin
				cmd_n   = CMD_SEND;
				cbyte_n = reg_n;
				st_n    = S_W_REG_CHK;
			end
			S_W_REG_CHK: begin
				if (!ebusy_s1) begin
					err_n = nak_s1;
					st_n  = nak_s1 ? S_W_END : S_W_DATA;
				end
			end
			S_W_DATA: begin
				cmd_n   = CMD_SEND;
				cbyte_n = buf_rd;
				st_n    = S_W_DATA_CHK;
			end
			S_W_DATA_CHK: begin
				if (!ebusy_s1) begin
					err_n = nak_s1;
					if (nak_s1) begin
						st_n = S_W_END;
					end else begin
						left_n    = left_dec;
						pos_n     = pos_inc;
						last_byte = (left_dec == 8'd0) || (pos_inc >= POS_DEPTH);
						st_n      = last_byte ? S_W_END : S_W_DATA;
					end
				end
			end
			S_W_END: begin
				cmd_n  = CMD_STOP;
				busy_n = 1'b0;
				wr_n   = 1'b0;
				st_n   = S_IDLE;
			end
			default: begin
				st_n = S_INIT;
			end
		endcase
	end

	// sequencer state update, one step per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_INIT;
			startup_cnt_q <= 16'd0;
			pos_q         <= '0;
			bytes_left_q  <= 8'd0;
			timeout_cnt_q <= 8'd0;
			tgt_addr_q    <= 7'd0;
			tgt_reg_q     <= 8'd0;
			busy_q        <= 1'b1;
			err_q         <= 1'b0;
			rd_q          <= 1'b0;
			wr_q          <= 1'b0;
		end else if (valid_s1 && advance) begin
			state_q       <= st_n;
			startup_cnt_q <= startup_n;
			pos_q         <= pos_n;
			bytes_left_q  <= left_n;
			timeout_cnt_q <= tmo_n;
			tgt_addr_q    <= addr_n;
			tgt_reg_q     <= reg_n;
			busy_q        <= busy_n;
			err_q         <= err_n;
			rd_q          <= rd_n;
			wr_q          <= wr_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			cmd_s2   <= cmd_n;
			cbyte_s2 <= cbyte_n;
			rxv_s2   <= rxv_n;
			rxi_s2   <= rxi_n;
			rxd_s2   <= rxd_n;
			busy_s2  <= busy_n;
			err_s2   <= err_n;
			rd_s2    <= rd_n;
			wr_s2    <= wr_n;
		end
	end

	assign out_valid     = valid_s2;
	assign command       = cmd_s2;
	assign command_byte  = cbyte_s2;
	assign rx_valid      = rxv_s2;
	assign rx_index      = rxi_s2;
	assign rx_data       = rxd_s2;
	assign busy_res      = busy_s2;
	assign comm_error    = err_s2;
	assign read_pending  = rd_s2;
	assign write_pending = wr_s2;

	// a delivered byte always goes with its ACK or NAK
	a_rx_with_ack: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rxv_s2 |-> (cmd_s2 == CMD_ACK) || (cmd_s2 == CMD_NAK))
		else $error("received byte delivered without ack/nak");

	// a data byte is only driven with a send command
	a_cbyte_send: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (cbyte_s2 != 8'd0) |-> (cmd_s2 == CMD_SEND))
		else $error("command byte set without send command");

	// when idle no transaction is left pending
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !busy_s2 |-> !rd_s2 && !wr_s2)
		else $error("request pending while not busy");

	// the step state only moves when a request is processed
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && advance) |=> $stable(state_q))
		else $error("sequencer state moved without a request");

endmodule : i2c_register_access_sequencer_unit
`default_nettype wire
